// File: rtl/tns_pkg.sv
// shared types, widths and constants of the streaming top-n selector
// used by the front, back and top modules of the block and by its checker
package tns_pkg;

	localparam int KEY_W           = 31;
	localparam int SCORE_W         = 32;
	localparam int KEEP_W          = 6;
	localparam int TDATA_W         = 64;
	localparam int TNS_TABLE_SLOTS = 32;
	localparam int TNS_QUEUE_DEPTH = 2;

	localparam logic [KEEP_W-1:0]         KEEP_RESET = 6'd20;
	localparam logic signed [SCORE_W-1:0] SCORE_MAX  = 32'sh7FFF_FFFF;

	// item kinds
	localparam logic KIND_OFFER  = 1'b0;
	localparam logic KIND_FINISH = 1'b1;

	// register index, taken from paddr[2]
	localparam logic REG_KEEP_COUNT = 1'b0;

	typedef struct packed {
		logic                      kind;
		logic [KEY_W-1:0]          key;
		logic signed [SCORE_W-1:0] score;
	} tns_item_t;

	typedef struct packed {
		logic [KEY_W-1:0]          key;
		logic signed [SCORE_W-1:0] score;
		logic                      last;
		logic                      none;
	} tns_result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE,
		ST_SORT,
		ST_EMIT,
		ST_EMPTY
	} tns_state_t;

	// order by score, then by key; true when a ranks below b
	function automatic logic lex_less(
		input logic signed [SCORE_W-1:0] sa,
		input logic [KEY_W-1:0]          ka,
		input logic signed [SCORE_W-1:0] sb,
		input logic [KEY_W-1:0]          kb
	);
		return (sa < sb) || ((sa == sb) && (ka < kb));
	endfunction

endpackage

// File: rtl/tns_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module tns_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/tns_front.sv
// front end: takes stream items, splits them into fields, holds them in a short queue
// depends on tns_pkg
module tns_front
	import tns_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,
	input  logic [0:0]         s_tuser,
	output logic               q_valid,
	input  logic               q_ready,
	output tns_item_t          q_item
);

	localparam int DEPTH = TNS_QUEUE_DEPTH;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW  = $clog2(DEPTH + 1);

	tns_item_t       mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CNTW-1:0] count_q;
	tns_item_t       in_item;
	logic            push;
	logic            pop;

	// decode the incoming item
	always_comb begin
		in_item.kind  = s_tuser[0];
		in_item.key   = s_tdata[KEY_W-1:0];
		in_item.score = s_tdata[KEY_W+SCORE_W-1:KEY_W];
	end

	assign s_tready = (count_q != CNTW'(DEPTH));
	assign q_valid  = (count_q != '0);
	assign q_item   = mem_q[rd_ptr_q];
	assign push     = s_tvalid && s_tready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

endmodule

// File: rtl/tns_back.sv
// back end: slot table in ram, offer scan and update, sorted emit on finish
// depends on tns_pkg and tns_ram
module tns_back
	import tns_pkg::*;
#(
	parameter int TABLE_SLOTS = TNS_TABLE_SLOTS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [KEEP_W-1:0] keep_count,
	input  logic              q_valid,
	output logic              q_ready,
	input  tns_item_t         q_item,
	output logic              out_valid,
	input  logic              out_ready,
	output tns_result_t       out_item
);

	localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int CW = $clog2(TABLE_SLOTS + 1);
	localparam int MW = (CW > KEEP_W) ? CW : KEEP_W;
	localparam int DW = KEY_W + SCORE_W;

	tns_state_t state_q;
	tns_state_t state_d;

	// table bookkeeping
	logic [CW-1:0]             held_q;
	logic [IW-1:0]             min_slot_q;
	logic signed [SCORE_W-1:0] min_score_q;
	logic [KEY_W-1:0]          min_key_q;

	tns_item_t cmd_q;

	// scan
	logic [CW-1:0] addr_q;
	logic          rd_valid_s1;
	logic [IW-1:0] rd_idx_s1;

	// offer scan results
	logic                      dup_q;
	logic                      run_found_q;
	logic signed [SCORE_W-1:0] run_score_q;
	logic [KEY_W-1:0]          run_key_q;
	logic [IW-1:0]             run_slot_q;

	// sort pass
	logic [CW-1:0]             pass_q;
	logic                      have_prev_q;
	logic [KEY_W-1:0]          prev_key_q;
	logic                      best_found_q;
	logic [KEY_W-1:0]          best_key_q;
	logic signed [SCORE_W-1:0] best_score_q;

	logic        out_valid_q;
	tns_result_t out_q;

	// ram
	logic                      ram_we;
	logic [IW-1:0]             ram_waddr;
	logic [DW-1:0]             ram_wdata;
	logic [DW-1:0]             ram_rdata;
	logic [KEY_W-1:0]          rd_key;
	logic signed [SCORE_W-1:0] rd_score;

	// decisions
	logic [MW-1:0] keep_w;
	logic [MW-1:0] limit_w;
	logic          held_empty;
	logic          can_append;
	logic          score_beats;
	logic          do_append;
	logic          do_replace;
	logic          issue;
	logic          out_free;
	logic          is_last;
	logic          load_out;
	tns_result_t   out_d;
	logic          new_beats_min;
	logic          new_beats_run;
	logic          sort_cand;
	logic          run_cand;

	tns_ram #(
		.WIDTH(DW),
		.DEPTH(TABLE_SLOTS)
	) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(addr_q[IW-1:0]),
		.rdata(ram_rdata)
	);

	assign rd_key   = ram_rdata[KEY_W-1:0];
	assign rd_score = ram_rdata[DW-1:KEY_W];

	assign keep_w      = MW'(keep_count);
	assign limit_w     = (keep_w > MW'(TABLE_SLOTS)) ? MW'(TABLE_SLOTS) : keep_w;
	assign held_empty  = (held_q == '0);
	assign can_append  = (MW'(held_q) < limit_w);
	assign score_beats = (min_score_q < cmd_q.score);
	assign out_free    = !out_valid_q || out_ready;
	assign is_last     = (CW'(pass_q + 1'b1) == held_q);

	assign new_beats_min = lex_less(cmd_q.score, cmd_q.key, min_score_q, min_key_q);
	assign new_beats_run = lex_less(cmd_q.score, cmd_q.key, run_score_q, run_key_q);
	assign sort_cand = (!have_prev_q || (rd_key > prev_key_q)) &&
		(!best_found_q || (rd_key < best_key_q));
	assign run_cand = (rd_idx_s1 != min_slot_q) &&
		(!run_found_q || lex_less(rd_score, rd_key, run_score_q, run_key_q));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					if (q_item.kind == KIND_FINISH) begin
						state_d = held_empty ? ST_EMPTY : ST_SORT;
					end else begin
						state_d = held_empty ? ST_UPDATE : ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (!issue && !rd_valid_s1) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				state_d = ST_IDLE;
			end
			ST_SORT: begin
				if (!issue && !rd_valid_s1) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = is_last ? ST_IDLE : ST_SORT;
				end
			end
			ST_EMPTY: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs of the state machine
	always_comb begin
		q_ready    = 1'b0;
		issue      = 1'b0;
		do_append  = 1'b0;
		do_replace = 1'b0;
		load_out   = 1'b0;
		out_d      = out_q;
		unique case (state_q)
			ST_IDLE: begin
				q_ready = 1'b1;
			end
			ST_SCAN, ST_SORT: begin
				issue = (addr_q < held_q);
			end
			ST_UPDATE: begin
				do_append  = !dup_q && can_append;
				do_replace = !dup_q && !can_append && !held_empty && score_beats;
			end
			ST_EMIT: begin
				load_out    = out_free;
				out_d.key   = best_key_q;
				out_d.score = best_score_q;
				out_d.last  = is_last;
				out_d.none  = 1'b0;
			end
			ST_EMPTY: begin
				load_out    = out_free;
				out_d.key   = '0;
				out_d.score = '0;
				out_d.last  = 1'b1;
				out_d.none  = 1'b1;
			end
			default: begin
				q_ready = 1'b0;
			end
		endcase
	end

	assign ram_we    = do_append || do_replace;
	assign ram_waddr = do_append ? held_q[IW-1:0] : min_slot_q;
	assign ram_wdata = {cmd_q.score, cmd_q.key};

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			held_q       <= '0;
			min_slot_q   <= '0;
			min_score_q  <= SCORE_MAX;
			addr_q       <= '0;
			rd_valid_s1  <= 1'b0;
			dup_q        <= 1'b0;
			run_found_q  <= 1'b0;
			pass_q       <= '0;
			have_prev_q  <= 1'b0;
			best_found_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_valid_s1 <= issue;
			if (issue) begin
				addr_q <= addr_q + 1'b1;
			end

			if (state_q == ST_IDLE && q_valid) begin
				addr_q       <= '0;
				dup_q        <= 1'b0;
				run_found_q  <= 1'b0;
				pass_q       <= '0;
				have_prev_q  <= 1'b0;
				best_found_q <= 1'b0;
			end

			if (state_q == ST_SCAN && rd_valid_s1) begin
				if (rd_key == cmd_q.key) begin
					dup_q <= 1'b1;
				end
				if (run_cand) begin
					run_found_q <= 1'b1;
				end
			end

			if (state_q == ST_SORT && rd_valid_s1 && sort_cand) begin
				best_found_q <= 1'b1;
			end

			// new minimum after a store
			if (do_append) begin
				held_q <= held_q + 1'b1;
				if (held_empty || new_beats_min) begin
					min_slot_q  <= held_q[IW-1:0];
					min_score_q <= cmd_q.score;
				end
			end else if (do_replace) begin
				if (run_found_q && !new_beats_run) begin
					min_slot_q  <= run_slot_q;
					min_score_q <= run_score_q;
				end else begin
					min_score_q <= cmd_q.score;
				end
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			// end of a finish run clears the table
			if (load_out && out_d.last) begin
				held_q      <= '0;
				min_slot_q  <= '0;
				min_score_q <= SCORE_MAX;
			end else if (state_q == ST_EMIT && load_out) begin
				pass_q       <= pass_q + 1'b1;
				have_prev_q  <= 1'b1;
				addr_q       <= '0;
				best_found_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		rd_idx_s1 <= addr_q[IW-1:0];
		if (state_q == ST_IDLE && q_valid) begin
			cmd_q <= q_item;
		end
		if (state_q == ST_SCAN && rd_valid_s1 && run_cand) begin
			run_score_q <= rd_score;
			run_key_q   <= rd_key;
			run_slot_q  <= rd_idx_s1;
		end
		if (state_q == ST_SORT && rd_valid_s1 && sort_cand) begin
			best_key_q   <= rd_key;
			best_score_q <= rd_score;
		end
		if (do_append && (held_empty || new_beats_min)) begin
			min_key_q <= cmd_q.key;
		end else if (do_replace) begin
			min_key_q <= (run_found_q && !new_beats_run) ? run_key_q : cmd_q.key;
		end
		if (state_q == ST_EMIT && load_out) begin
			prev_key_q <= best_key_q;
		end
		if (load_out) begin
			out_q <= out_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

// File: rtl/streaming_top_n_selector.sv
// streaming top-n selector: keeps the best-scoring (key, score) pairs of a stream
// an offer reads every held entry through the single read port of the slot ram and skips
// that scan with the table empty; a finish emits one sorted result per ram pass over the held
// entries, or a lone none_kept marker when the table is empty;
// a two-item input queue and a one-deep output register let input and output stall apart
// async reset empties table and queue, keep_count returns to 20; slot contents stay undefined
module streaming_top_n_selector
	import tns_pkg::*;
#(
	parameter int TABLE_SLOTS = TNS_TABLE_SLOTS
) (
	input  logic               clk,
	input  logic               arst_n,
	// input items
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,   // entry_key [30:0], entry_score [62:31], zero pad [63]
	input  logic [0:0]         s_tuser,   // kind [0]
	// result items
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,   // kept_key [30:0], kept_score [62:31], zero pad [63]
	output logic               m_tlast,   // last_of_run
	output logic [0:0]         m_tuser,   // none_kept [0]
	// configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic [KEEP_W-1:0] keep_count_q;
	logic              cfg_write;

	logic        q_valid;
	logic        q_ready;
	tns_item_t   q_item;
	logic        out_valid;
	tns_result_t out_item;

	// register file: keep_count at byte addresses 0 to 3 (paddr[2] low), addresses 4 to 7 read as zero
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_count_q <= KEEP_RESET;
		end else if (cfg_write && (paddr[2] == REG_KEEP_COUNT)) begin
			keep_count_q <= pwdata[KEEP_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_KEEP_COUNT) ? 32'(keep_count_q) : '0;

	// front: unpack and queue items
	tns_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_item  (q_item)
	);

	// back: table update, sorted emit on finish
	tns_back #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.keep_count(keep_count_q),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_item    (q_item),
		.out_valid (out_valid),
		.out_ready (m_tready),
		.out_item  (out_item)
	);

	// pack the result item
	assign m_tvalid = out_valid;
	assign m_tdata  = {(TDATA_W - KEY_W - SCORE_W)'(0), out_item.score, out_item.key};
	assign m_tlast  = out_item.last;
	assign m_tuser  = out_item.none;

endmodule

// File: rtl/tns_checker.sv
// port-level checks on the streaming top-n selector, bound to the top level
// depends on tns_pkg
module tns_checker
	import tns_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [TDATA_W-1:0] m_tdata,
	input logic               m_tlast,
	input logic [0:0]         m_tuser,
	input logic               psel,
	input logic               penable,
	input logic               pwrite,
	input logic [2:0]         paddr,
	input logic [31:0]        pwdata,
	input logic [31:0]        prdata,
	input logic               pready
);

	logic             in_run_q;
	logic [KEY_W-1:0] prev_key_q;
	logic             out_acc;

	assign out_acc = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_run_q <= 1'b0;
		end else if (out_acc) begin
			in_run_q <= !m_tlast;
		end
	end

	always_ff @(posedge clk) begin
		if (out_acc) begin
			prev_key_q <= m_tdata[KEY_W-1:0];
		end
	end

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("result changed while stalled");

	// empty marker is a lone zero item
	a_empty_marker: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tlast && (m_tdata == '0))
		else $error("empty marker malformed");

	// keys of one run rise strictly
	a_key_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && in_run_q |-> m_tdata[KEY_W-1:0] > prev_key_q)
		else $error("kept keys out of order");

	// keep_count reads back what was written
	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && pready && (paddr[2] == REG_KEEP_COUNT))
			##1 (psel && !pwrite && (paddr[2] == REG_KEEP_COUNT))
			|-> prdata[KEEP_W-1:0] == $past(pwdata[KEEP_W-1:0]))
		else $error("keep_count readback mismatch");

endmodule

bind streaming_top_n_selector tns_checker u_tns_checker (.*);
